// ----- design/ptcr_pkg.sv -----
// Shared types, widths and constants for the PID controller with clamp and ramp.
// No dependencies; imported by every module of the block.
`default_nettype none

package ptcr_pkg;

    localparam int DATA_W  = 32;
    localparam int FRAC_W  = 16;
    localparam int LIM_W   = 31;
    localparam int CFG_W   = (DATA_W > LIM_W) ? DATA_W : LIM_W;
    localparam int EXT_W   = CFG_W + 3;
    localparam int TDATA_W = ((DATA_W + 7) / 8) * 8;
    localparam int IDX_W   = 3;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic signed [EXT_W-1:0]  ext_t;
    typedef logic [LIM_W-1:0]         lim_t;

    typedef enum logic [IDX_W-1:0] {
        IDX_KP         = 3'd0,
        IDX_KI_HALF_TS = 3'd1,
        IDX_KD_OVER_TS = 3'd2,
        IDX_LIMIT      = 3'd3,
        IDX_RAMP_STEP  = 3'd4
    } cfg_idx_t;

    // Enables of the two multiplier stages
    typedef struct packed {
        logic mul;
        logic sat;
    } fmul_en_t;

    localparam data_t DMAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam data_t DMIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam ext_t  XMAX = ext_t'(DMAX);
    localparam ext_t  XMIN = ext_t'(DMIN);

    // Saturate a wide signed value to the data range
    function automatic data_t sat_data(input ext_t v);
        data_t r;
        if (v > XMAX)
            r = DMAX;
        else if (v < XMIN)
            r = DMIN;
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- design/pid_tustin_clamp_ramp.sv -----
// Top level of the PID controller: stream ports, configuration, pipeline and state.
// Depends on ptcr_pkg and ptcr_fmul.
//
// One error sample in, one drive value out, at a sustained rate of one transfer per
// clock cycle while the receiver holds m_axis_tready high. The pipeline has five
// stages: error sum and difference, three products, product saturation, the integral
// update and P+D sum, and the output clamp and ramp limit. The rate is set by the
// three state loops, last error, integral and last output, each of which closes in
// a single stage. Each stage holds its item until the next one is free, so the block
// keeps taking new samples while a finished result waits, until every stage is full.
// Configuration is a plain write port; write it only while no sample is in flight.
`default_nettype none

module pid_tustin_clamp_ramp
    import ptcr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // configuration write port
    input  wire logic               cfg_we,
    input  wire logic [IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_W-1:0]   cfg_data,
    // error samples
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [TDATA_W-1:0] s_axis_tdata,   // [DATA_W-1:0] error_in
    // drive values
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [TDATA_W-1:0]      m_axis_tdata    // [DATA_W-1:0] drive_out
);

    // ---------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------
    data_t kp_reg;
    data_t ki_reg;
    data_t kd_reg;
    lim_t  limit_reg;
    lim_t  ramp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg    <= '0;
            ki_reg    <= '0;
            kd_reg    <= '0;
            limit_reg <= '1;
            ramp_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                IDX_KP:         kp_reg    <= cfg_data[DATA_W-1:0];
                IDX_KI_HALF_TS: ki_reg    <= cfg_data[DATA_W-1:0];
                IDX_KD_OVER_TS: kd_reg    <= cfg_data[DATA_W-1:0];
                IDX_LIMIT:      limit_reg <= cfg_data[LIM_W-1:0];
                IDX_RAMP_STEP:  ramp_reg  <= cfg_data[LIM_W-1:0];
                default:        ; // drop writes beyond the register list
            endcase
        end
    end

    // Effective limit: a limit beyond the data range acts as the largest value
    ext_t lim_x;
    ext_t lim_raw;
    ext_t ramp_x;

    assign lim_raw = ext_t'(limit_reg);
    assign lim_x   = (lim_raw > XMAX) ? XMAX : lim_raw;
    assign ramp_x  = ext_t'(ramp_reg);

    function automatic ext_t clamp_lim(input ext_t v, input ext_t lim);
        ext_t r;
        if (v < -lim)
            r = -lim;
        else if (v > lim)
            r = lim;
        else
            r = v;
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Pipeline flow control: each stage loads when it is empty or the
    // stage after it moves on
    // ---------------------------------------------------------------------
    logic v0_reg, v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;
    logic ld0, ld1, ld2, ld3, ld4;

    assign rdy4          = !v4_reg || m_axis_tready;
    assign rdy3          = !v3_reg || rdy4;
    assign rdy2          = !v2_reg || rdy3;
    assign rdy1          = !v1_reg || rdy2;
    assign s_axis_tready = !v0_reg || rdy1;

    assign ld0 = s_axis_tvalid && s_axis_tready;
    assign ld1 = v0_reg && rdy1;
    assign ld2 = v1_reg && rdy2;
    assign ld3 = v2_reg && rdy3;
    assign ld4 = v3_reg && rdy4;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= ld0 || (v0_reg && !ld1);
            v1_reg <= ld1 || (v1_reg && !ld2);
            v2_reg <= ld2 || (v2_reg && !ld3);
            v3_reg <= ld3 || (v3_reg && !ld4);
            v4_reg <= ld4 || (v4_reg && !m_axis_tready);
        end
    end

    // ---------------------------------------------------------------------
    // Stage 0: saturated error sum and difference against the last error
    // ---------------------------------------------------------------------
    data_t error_in;
    data_t last_err_reg;
    data_t err0_reg;
    data_t sum0_reg;
    data_t dif0_reg;
    data_t sum0_next;
    data_t dif0_next;

    assign error_in  = s_axis_tdata[DATA_W-1:0];
    assign sum0_next = sat_data(ext_t'(error_in) + ext_t'(last_err_reg));
    assign dif0_next = sat_data(ext_t'(error_in) - ext_t'(last_err_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_err_reg <= '0;
        else if (ld0)
            last_err_reg <= error_in;
    end

    always_ff @(posedge clk)
    begin
        if (ld0)
        begin
            err0_reg <= error_in;
            sum0_reg <= sum0_next;
            dif0_reg <= dif0_next;
        end
    end

    // ---------------------------------------------------------------------
    // Stages 1 and 2: the three products, then floor shift and saturation
    // ---------------------------------------------------------------------
    fmul_en_t mul_en;
    data_t    p2;
    data_t    i2;
    data_t    d2;

    assign mul_en.mul = ld1;
    assign mul_en.sat = ld2;

    ptcr_fmul u_mul_p
    (
        .clk    (clk),
        .en     (mul_en),
        .a      (kp_reg),
        .b      (err0_reg),
        .result (p2)
    );

    ptcr_fmul u_mul_i
    (
        .clk    (clk),
        .en     (mul_en),
        .a      (ki_reg),
        .b      (sum0_reg),
        .result (i2)
    );

    ptcr_fmul u_mul_d
    (
        .clk    (clk),
        .en     (mul_en),
        .a      (kd_reg),
        .b      (dif0_reg),
        .result (d2)
    );

    // ---------------------------------------------------------------------
    // Stage 3: integral update (clamped; the clamp also covers saturation
    // since the limit never exceeds the data range) and the P+D sum
    // ---------------------------------------------------------------------
    data_t acc_reg;
    data_t acc_next;
    ext_t  acc_sum;
    ext_t  pd3_reg;
    ext_t  pd3_next;

    assign acc_sum  = clamp_lim(ext_t'(acc_reg) + ext_t'(i2), lim_x);
    assign acc_next = acc_sum[DATA_W-1:0];
    assign pd3_next = ext_t'(p2) + ext_t'(d2);

    // The integral register doubles as this stage's I term: it only changes
    // when stage 3 loads, by which time stage 4 has taken the previous item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acc_reg <= '0;
        else if (ld3)
            acc_reg <= acc_next;
    end

    always_ff @(posedge clk)
    begin
        if (ld3)
            pd3_reg <= pd3_next;
    end

    // ---------------------------------------------------------------------
    // Stage 4: output clamp and ramp limit; the result register is also
    // the last output
    // ---------------------------------------------------------------------
    data_t drive_reg;
    data_t drive_next;
    ext_t  y_clamp;
    ext_t  last_x;
    ext_t  delta;

    assign y_clamp = clamp_lim(pd3_reg + ext_t'(acc_reg), lim_x);
    assign last_x  = ext_t'(drive_reg);
    assign delta   = y_clamp - last_x;

    always_comb
    begin
        if (ramp_reg != '0 && delta > ramp_x)
            drive_next = sat_data(last_x + ramp_x);
        else if (ramp_reg != '0 && delta < -ramp_x)
            drive_next = sat_data(last_x - ramp_x);
        else
            drive_next = y_clamp[DATA_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            drive_reg <= '0;
        else if (ld4)
            drive_reg <= drive_next;
    end

    assign m_axis_tvalid = v4_reg;
    assign m_axis_tdata  = TDATA_W'($unsigned(drive_reg));

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------

    // Ramp limiting: one output never moves further than the step
    a_ramp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        $past(ld4) && ($past(ramp_reg) != '0) |->
            ((ext_t'(drive_reg) - ext_t'($past(drive_reg))) <= ext_t'($past(ramp_reg))) &&
            ((ext_t'(drive_reg) - ext_t'($past(drive_reg))) >= -ext_t'($past(ramp_reg))))
        else $error("drive change exceeds ramp step");

    // Zero limit with no ramp forces the output to zero
    a_zero_limit: assert property (@(posedge clk) disable iff (!rst_n)
        $past(ld4) && ($past(limit_reg) == '0) && ($past(ramp_reg) == '0) |->
            drive_reg == '0)
        else $error("output not zero under zero limit");

    // Integral state moves only when stage 3 takes an item
    a_acc_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !ld3 |=> $stable(acc_reg))
        else $error("integral changed without a stage 3 load");

    // A stage 3 item blocked by a full, stalled output stage is kept
    a_s3_keep: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && v4_reg && !m_axis_tready |=> v3_reg && $stable(pd3_reg))
        else $error("stage 3 item lost during stall");

endmodule

`default_nettype wire

// ----- design/ptcr_fmul.sv -----
// Two-stage fixed-point multiplier: full product, then floor shift and saturation.
// Depends on ptcr_pkg.
`default_nettype none

module ptcr_fmul
    import ptcr_pkg::*;
(
    input  wire logic     clk,
    input  wire fmul_en_t en,
    input  wire data_t    a,
    input  wire data_t    b,
    output data_t         result
);

    localparam int PROD_W = 2 * DATA_W;
    localparam int TOP_LO = DATA_W + FRAC_W - 1;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    data_t                    result_reg;
    data_t                    result_next;
    logic [PROD_W-1:TOP_LO]   top_bits;

    assign prod_next = PROD_W'(a) * PROD_W'(b);
    assign top_bits  = prod_reg[PROD_W-1:TOP_LO];

    // Shifted product fits only if the bits above it are all sign copies
    always_comb
    begin
        if ((&top_bits) || !(|top_bits))
            result_next = prod_reg[TOP_LO:FRAC_W];
        else if (prod_reg[PROD_W-1])
            result_next = DMIN;
        else
            result_next = DMAX;
    end

    always_ff @(posedge clk)
    begin
        if (en.mul)
            prod_reg <= prod_next;
        if (en.sat)
            result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

`default_nettype wire

// ----- tb/sv/pid_tustin_clamp_ramp_tb.sv -----
// Self-checking bench for pid_tustin_clamp_ramp: directed extremes, then randomised
// settings and error streams under varied back-pressure. Depends on ptcr_pkg and the RTL.
`timescale 1ns / 100ps

module pid_tustin_clamp_ramp_tb;
    import ptcr_pkg::*;

    // Mirror of the controller: own copy of registers and loop state, and the
    // queue of drive values still owed by the block.
    class drive_ledger;
        data_t  kp;
        data_t  ki_half_ts;
        data_t  kd_over_ts;
        lim_t   limit;
        lim_t   ramp_step;
        data_t  integral_acc;
        data_t  last_error;
        data_t  last_output;
        data_t  drive_due[$];
        int     failures;

        function new();
            kp           = '0;
            ki_half_ts   = '0;
            kd_over_ts   = '0;
            limit        = '1;
            ramp_step    = '0;
            integral_acc = '0;
            last_error   = '0;
            last_output  = '0;
            failures     = 0;
        endfunction

        function data_t clip32(longint v);
            if (v > longint'(DMAX))
                return DMAX;
            if (v < longint'(DMIN))
                return DMIN;
            return data_t'(v);
        endfunction

        // Q16.16 product: exact 64-bit product, floor shift, saturate
        function data_t q_mul(data_t a, data_t b);
            longint prod;
            prod = longint'(a) * longint'(b);
            return clip32(prod >>> FRAC_W);
        endfunction

        function longint clamp_sym(longint v, longint lim);
            if (v > lim)
                return lim;
            if (v < -lim)
                return -lim;
            return v;
        endfunction

        function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] v);
            case (idx)
                IDX_KP:         kp         = data_t'(v);
                IDX_KI_HALF_TS: ki_half_ts = data_t'(v);
                IDX_KD_OVER_TS: kd_over_ts = data_t'(v);
                IDX_LIMIT:      limit      = v[LIM_W-1:0];
                IDX_RAMP_STEP:  ramp_step  = v[LIM_W-1:0];
                default:        ;
            endcase
        endfunction

        // Work out the drive value owed for one accepted error sample
        function void note_error(data_t e);
            longint lim;
            longint rate;
            longint p;
            longint i;
            longint d;
            longint y;
            longint diff;
            lim  = longint'({1'b0, limit});
            rate = longint'({1'b0, ramp_step});
            p = q_mul(kp, e);
            i = longint'(integral_acc)
                + longint'(q_mul(ki_half_ts, clip32(longint'(e) + longint'(last_error))));
            i = clamp_sym(longint'(clip32(i)), lim);
            d = q_mul(kd_over_ts, clip32(longint'(e) - longint'(last_error)));
            y = clamp_sym(p + i + d, lim);
            if (rate != 0)
            begin
                diff = y - longint'(last_output);
                if (diff > rate)
                    y = clip32(longint'(last_output) + rate);
                else if (diff < -rate)
                    y = clip32(longint'(last_output) - rate);
            end
            integral_acc = data_t'(i);
            last_error   = e;
            last_output  = data_t'(y);
            drive_due.push_back(data_t'(y));
        endfunction

        function void check_drive(logic [TDATA_W-1:0] word);
            data_t got;
            data_t want;
            got = data_t'(word[DATA_W-1:0]);
            if (drive_due.size() == 0)
            begin
                $display("%0t: drive value %h with nothing expected", $time, got);
                failures++;
            end
            else
            begin
                want = drive_due.pop_front();
                if (got !== want)
                begin
                    $display("%0t: drive_out expected %h, got %h", $time, want, got);
                    failures++;
                end
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic [IDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]   cfg_data;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [TDATA_W-1:0] s_axis_tdata;    // [DATA_W-1:0] error_in
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [TDATA_W-1:0] m_axis_tdata;    // [DATA_W-1:0] drive_out

    drive_ledger ledger;
    int          send_idle_pct = 16;
    int          recv_idle_pct = 68;
    data_t       walk;

    pid_tustin_clamp_ramp uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 clk = ~clk;

    // Receiver: stall at random on the falling edge; a zero rate means never stall
    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

    // Check every drive transfer against the oldest value owed
    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            ledger.check_drive(m_axis_tdata);

    // Write one register while the block is idle; hold the enable for a single edge
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        ledger.write_reg(idx, v);
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_all(input logic [CFG_W-1:0] p, input logic [CFG_W-1:0] i,
                           input logic [CFG_W-1:0] d, input logic [CFG_W-1:0] lim,
                           input logic [CFG_W-1:0] rate);
        write_reg(IDX_KP, p);
        write_reg(IDX_KI_HALF_TS, i);
        write_reg(IDX_KD_OVER_TS, d);
        write_reg(IDX_LIMIT, lim);
        write_reg(IDX_RAMP_STEP, rate);
    endtask

    // Offer one error sample, idling the sender at random first; the ledger
    // notes it on the edge that completes the transfer.
    task automatic send_error(input data_t e);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= $urandom;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= e;
        do
            @(posedge clk);
        while (!s_axis_tready);
        ledger.note_error(e);
    endtask

    // Drop valid and wait until every owed drive value has come out
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (ledger.drive_due.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [CFG_W-1:0] pick_gain();
        case ($urandom_range(9))
            0:       return DMAX;
            1:       return DMIN;
            2:       return '0;
            3, 4:    return $urandom;
            default: return int'($urandom_range(0, 1 << 19)) - (1 << 18);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_limit();
        case ($urandom_range(5))
            0:       return '0;
            1:       return DMAX;
            2:       return $urandom;    // top bit is dropped by the block
            default: return $urandom_range(0, 32 << FRAC_W);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_ramp();
        case ($urandom_range(6))
            0, 1, 2: return '0;
            3:       return $urandom;
            4:       return DMAX;
            default: return $urandom_range(1, 1 << FRAC_W);
        endcase
    endfunction

    // Mostly a slow random walk so the integral and ramp have something to track,
    // with full-range noise and extremes mixed in.
    function automatic data_t pick_error();
        int w;
        case ($urandom_range(9))
            0, 1:
                return $urandom;
            2:
                case ($urandom_range(4))
                    0:       return DMAX;
                    1:       return DMIN;
                    2:       return '0;
                    3:       return 1;
                    default: return -1;
                endcase
            default:
            begin
                w = int'(walk) + int'($urandom_range(0, 1 << 18)) - (1 << 17);
                if (w > (64 << FRAC_W))
                    w = 64 << FRAC_W;
                else if (w < -(64 << FRAC_W))
                    w = -(64 << FRAC_W);
                walk = w;
                return walk;
            end
        endcase
    endfunction

    task automatic shuffle_settings();
        int k;
        set_all(pick_gain(), pick_gain(), pick_gain(), pick_limit(), pick_ramp());
        // now and then hit an index the block must ignore
        if ($urandom_range(2) == 0)
            for (k = IDX_RAMP_STEP + 1; k < (1 << IDX_W); k++)
                write_reg(k[IDX_W-1:0], $urandom);
    endtask

    initial
    begin
        int phase;
        int burst;
        int n;
        ledger        = new();
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        walk          = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset values: all gains zero, so the drive stays at zero
        send_error(1);
        send_error(-1);
        send_error(DMAX);
        drain();

        // Gains of 1, 1/2 and 1/4, full limit, no ramp: error extremes and overflowing sum/difference
        set_all(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, DMAX, '0);
        send_error(DMAX);
        send_error(DMIN);
        send_error(DMIN);
        send_error(DMAX);
        send_error('0);
        send_error(1);
        send_error(-1);
        send_error(32'sh0001_0000);
        send_error(-32'sh0001_0000);
        drain();

        // Zero limit forces integral and drive to zero; stray indexes change nothing
        write_reg(IDX_LIMIT, '0);
        write_reg(IDX_W'(IDX_RAMP_STEP + 1), '1);
        write_reg(IDX_W'((1 << IDX_W) - 1), '1);
        send_error(DMAX);
        send_error(DMIN);
        send_error(32'sh0003_0039);
        drain();

        // Extreme gains push most products into saturation; all-ones limit word with widest ramp
        set_all(DMIN, DMAX, DMIN, 32'hFFFF_FFFF, DMAX);
        send_error(DMAX);
        send_error(DMIN);
        drain();

        // Tight limit and a small ramp step: large steps get slew-limited both ways
        set_all(32'h0002_0000, 32'h0000_1000, 32'h0000_2000, 32'h0005_0000, 32'h0000_8000);
        send_error(32'sh0010_0000);
        send_error(32'sh0010_0000);
        send_error(-32'sh0010_0000);
        send_error('0);
        drain();

        // Random settings and error streams; the idle rates swap, then both stop
        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 16;
                    recv_idle_pct = 68;
                end
                1:
                begin
                    send_idle_pct = 68;
                    recv_idle_pct = 16;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (burst = 0; burst < 7; burst++)
            begin
                shuffle_settings();
                for (n = 0; n < 50; n++)
                    send_error(pick_error());
                drain();
            end
        end

        // Allow the pipeline to settle so any stray transfer is caught
        repeat (12) @(posedge clk);
        if (ledger.failures == 0)
            $display("PASS pid_tustin_clamp_ramp");
        else
            $display("FAIL pid_tustin_clamp_ramp");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial
    begin
        #20_000_000;
        $display("FAIL pid_tustin_clamp_ramp");
        $finish;
    end

endmodule

// ----- files.f -----
design/ptcr_pkg.sv
design/ptcr_fmul.sv
design/pid_tustin_clamp_ramp.sv
tb/sv/pid_tustin_clamp_ramp_tb.sv
